[rtl/core/aes_pkg.sv]
// AES-128 package: constants, types, S-box tables and round helper functions.
package aes_pkg;

    localparam int ROUND_COUNT = 10;
    localparam int RK_DEPTH    = ROUND_COUNT + 1;
    localparam int RK_ADDR_W   = $clog2(RK_DEPTH);
    localparam logic [RK_ADDR_W-1:0] LAST_ROUND = RK_ADDR_W'(ROUND_COUNT);

    // Request codes
    localparam logic REQ_ENCRYPT = 1'b0;
    localparam logic REQ_DECRYPT = 1'b1;

    // Control handed to the round unit
    typedef struct packed {
        logic decrypt;
        logic last;
    } aes_round_ctl_t;

    localparam logic [7:0] FWD_SBOX [256] = '{
        8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
        8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
        8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
        8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
        8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
        8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
        8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
        8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
        8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
        8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
        8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
        8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
        8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
        8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
        8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
        8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
    };

    localparam logic [7:0] INV_SUB_LUT [256] = '{
        8'h52,8'h09,8'h6A,8'hD5,8'h30,8'h36,8'hA5,8'h38,8'hBF,8'h40,8'hA3,8'h9E,8'h81,8'hF3,8'hD7,8'hFB,
        8'h7C,8'hE3,8'h39,8'h82,8'h9B,8'h2F,8'hFF,8'h87,8'h34,8'h8E,8'h43,8'h44,8'hC4,8'hDE,8'hE9,8'hCB,
        8'h54,8'h7B,8'h94,8'h32,8'hA6,8'hC2,8'h23,8'h3D,8'hEE,8'h4C,8'h95,8'h0B,8'h42,8'hFA,8'hC3,8'h4E,
        8'h08,8'h2E,8'hA1,8'h66,8'h28,8'hD9,8'h24,8'hB2,8'h76,8'h5B,8'hA2,8'h49,8'h6D,8'h8B,8'hD1,8'h25,
        8'h72,8'hF8,8'hF6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hD4,8'hA4,8'h5C,8'hCC,8'h5D,8'h65,8'hB6,8'h92,
        8'h6C,8'h70,8'h48,8'h50,8'hFD,8'hED,8'hB9,8'hDA,8'h5E,8'h15,8'h46,8'h57,8'hA7,8'h8D,8'h9D,8'h84,
        8'h90,8'hD8,8'hAB,8'h00,8'h8C,8'hBC,8'hD3,8'h0A,8'hF7,8'hE4,8'h58,8'h05,8'hB8,8'hB3,8'h45,8'h06,
        8'hD0,8'h2C,8'h1E,8'h8F,8'hCA,8'h3F,8'h0F,8'h02,8'hC1,8'hAF,8'hBD,8'h03,8'h01,8'h13,8'h8A,8'h6B,
        8'h3A,8'h91,8'h11,8'h41,8'h4F,8'h67,8'hDC,8'hEA,8'h97,8'hF2,8'hCF,8'hCE,8'hF0,8'hB4,8'hE6,8'h73,
        8'h96,8'hAC,8'h74,8'h22,8'hE7,8'hAD,8'h35,8'h85,8'hE2,8'hF9,8'h37,8'hE8,8'h1C,8'h75,8'hDF,8'h6E,
        8'h47,8'hF1,8'h1A,8'h71,8'h1D,8'h29,8'hC5,8'h89,8'h6F,8'hB7,8'h62,8'h0E,8'hAA,8'h18,8'hBE,8'h1B,
        8'hFC,8'h56,8'h3E,8'h4B,8'hC6,8'hD2,8'h79,8'h20,8'h9A,8'hDB,8'hC0,8'hFE,8'h78,8'hCD,8'h5A,8'hF4,
        8'h1F,8'hDD,8'hA8,8'h33,8'h88,8'h07,8'hC7,8'h31,8'hB1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hEC,8'h5F,
        8'h60,8'h51,8'h7F,8'hA9,8'h19,8'hB5,8'h4A,8'h0D,8'h2D,8'hE5,8'h7A,8'h9F,8'h93,8'hC9,8'h9C,8'hEF,
        8'hA0,8'hE0,8'h3B,8'h4D,8'hAE,8'h2A,8'hF5,8'hB0,8'hC8,8'hEB,8'hBB,8'h3C,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2B,8'h04,8'h7E,8'hBA,8'h77,8'hD6,8'h26,8'hE1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0C,8'h7D
    };

    function automatic logic [7:0] xtime(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1B : 8'h00);
    endfunction

    // Round constant for key expansion step n (1..10)
    function automatic logic [7:0] rcon(input logic [RK_ADDR_W-1:0] n);
        logic [7:0] r;
        unique case (n)
            4'd1:    r = 8'h01;
            4'd2:    r = 8'h02;
            4'd3:    r = 8'h04;
            4'd4:    r = 8'h08;
            4'd5:    r = 8'h10;
            4'd6:    r = 8'h20;
            4'd7:    r = 8'h40;
            4'd8:    r = 8'h80;
            4'd9:    r = 8'h1B;
            4'd10:   r = 8'h36;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {FWD_SBOX[w[31:24]], FWD_SBOX[w[23:16]], FWD_SBOX[w[15:8]], FWD_SBOX[w[7:0]]};
    endfunction

    // Next round key from the previous one
    function automatic logic [127:0] key_step(input logic [127:0] rk,
                                              input logic [RK_ADDR_W-1:0] n);
        logic [31:0] t;
        logic [31:0] n0;
        logic [31:0] n1;
        logic [31:0] n2;
        logic [31:0] n3;
        t  = sub_word({rk[23:0], rk[31:24]}) ^ {rcon(n), 24'h0};
        n0 = rk[127:96] ^ t;
        n1 = rk[95:64] ^ n0;
        n2 = rk[63:32] ^ n1;
        n3 = rk[31:0] ^ n2;
        return {n0, n1, n2, n3};
    endfunction

    // Round key index used at round step n
    function automatic logic [RK_ADDR_W-1:0] key_index(input logic dec,
                                                       input logic [RK_ADDR_W-1:0] n);
        return dec ? (LAST_ROUND - n) : n;
    endfunction

    function automatic logic [127:0] shift_rows(input logic [127:0] s, input logic inv);
        logic [127:0] t;
        int src;
        t = '0;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                src = inv ? ((c - r + 4) & 3) : ((c + r) & 3);
                t[127 - 8 * (c * 4 + r) -: 8] = s[127 - 8 * (src * 4 + r) -: 8];
            end
        end
        return t;
    endfunction

    function automatic logic [31:0] mix_col_fwd(input logic [31:0] a);
        logic [7:0] a0;
        logic [7:0] a1;
        logic [7:0] a2;
        logic [7:0] a3;
        a0 = a[31:24];
        a1 = a[23:16];
        a2 = a[15:8];
        a3 = a[7:0];
        return {xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3,
                a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3,
                a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3,
                xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3)};
    endfunction

    function automatic logic [31:0] mix_col_inv(input logic [31:0] a);
        logic [7:0] b [4];
        logic [7:0] m9 [4];
        logic [7:0] mb [4];
        logic [7:0] md [4];
        logic [7:0] me [4];
        logic [7:0] x2;
        logic [7:0] x4;
        logic [7:0] x8;
        for (int k = 0; k < 4; k++) begin
            b[k]  = a[31 - 8 * k -: 8];
            x2    = xtime(b[k]);
            x4    = xtime(x2);
            x8    = xtime(x4);
            m9[k] = x8 ^ b[k];
            mb[k] = x8 ^ x2 ^ b[k];
            md[k] = x8 ^ x4 ^ b[k];
            me[k] = x8 ^ x4 ^ x2;
        end
        return {me[0] ^ mb[1] ^ md[2] ^ m9[3],
                m9[0] ^ me[1] ^ mb[2] ^ md[3],
                md[0] ^ m9[1] ^ me[2] ^ mb[3],
                mb[0] ^ md[1] ^ m9[2] ^ me[3]};
    endfunction

endpackage

[rtl/core/aes_if.sv]
// Valid/ready channel interfaces for the cipher's request and result words.
interface aes_in_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [63:0] block_high;
    logic [63:0] block_low;

    modport source (output valid, req_type, block_high, block_low, input ready);
    modport sink (input valid, req_type, block_high, block_low, output ready);
endinterface

interface aes_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] out_high;
    logic [63:0] out_low;

    modport source (output valid, out_high, out_low, input ready);
    modport sink (input valid, out_high, out_low, output ready);
endinterface

[rtl/core/aes_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module aes_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 11
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write, then register the read word
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/core/aes_round.sv]
// One AES round, forward or inverse, shared by every round step.
module aes_round
    import aes_pkg::*;
(
    input  logic [127:0]   blk,
    input  logic [127:0]   round_key,
    input  aes_round_ctl_t ctl,
    output logic [127:0]   result
);

    logic [127:0] fwd_sub;
    logic [127:0] fwd_shift;
    logic [127:0] fwd_mix;
    logic [127:0] inv_shift;
    logic [127:0] inv_sub;
    logic [127:0] inv_add;
    logic [127:0] inv_mix;

    // Forward path: substitute, shift, mix
    always_comb
    begin
        for (int i = 0; i < 16; i++)
        begin
            fwd_sub[127 - 8 * i -: 8] = FWD_SBOX[blk[127 - 8 * i -: 8]];
        end
        fwd_shift = shift_rows(fwd_sub, 1'b0);
        for (int c = 0; c < 4; c++)
        begin
            fwd_mix[127 - 32 * c -: 32] = mix_col_fwd(fwd_shift[127 - 32 * c -: 32]);
        end
    end

    // Inverse path: shift, substitute, add key, mix
    always_comb
    begin
        inv_shift = shift_rows(blk, 1'b1);
        for (int i = 0; i < 16; i++)
        begin
            inv_sub[127 - 8 * i -: 8] = INV_SUB_LUT[inv_shift[127 - 8 * i -: 8]];
        end
        inv_add = inv_sub ^ round_key;
        for (int c = 0; c < 4; c++)
        begin
            inv_mix[127 - 32 * c -: 32] = mix_col_inv(inv_add[127 - 32 * c -: 32]);
        end
    end

    // Select direction; drop the mix on the last round
    always_comb
    begin
        if (ctl.decrypt)
        begin
            result = ctl.last ? inv_add : inv_mix;
        end
        else
        begin
            result = (ctl.last ? fwd_shift : fwd_mix) ^ round_key;
        end
    end

endmodule

[rtl/core/aes128_block_cipher_top.sv]
// AES-128 ECB cipher top level: key registers, key schedule and round sequencer.
//
// Usage: write the key through the APB port (key_high at 0x0, key_low at 0x8).
// Each write expands the round key schedule into an 11-entry RAM, one round
// key per cycle; in_ch.ready stays low meanwhile. in_ch carries one request
// word: req_type (0 encrypt, 1 decrypt) and the block. It is taken when
// in_ch.ready is high, which is whenever the round sequencer is idle and no
// key write is in progress. ST_ADD0 applies the first round key, then
// ST_ROUND runs the rounds one after another through the shared round unit,
// reading one round key per cycle from the schedule RAM while it advances.
// The result is registered as the last round completes and the sequencer
// returns to idle with it, so a new request can be taken in the same cycle
// that the result appears on out_ch. The result sits in an output register,
// so the next block may start while it waits; if the receiver still stalls
// when the next block finishes, the last round holds until the output
// register frees. Reset clears the key to zero and expands the all-zero key
// schedule before the first request is taken.
module aes128_block_cipher_top
    import aes_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    aes_in_if.sink      in_ch,
    aes_out_if.source   out_ch
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_KEXP  = 4'b0010,
        ST_ADD0  = 4'b0100,
        ST_ROUND = 4'b1000
    } state_t;

    state_t                 state_reg, state_next;
    logic [RK_ADDR_W-1:0]   kcnt_reg, kcnt_next;
    logic [RK_ADDR_W-1:0]   rcnt_reg, rcnt_next;
    logic [63:0]            key_high_reg, key_high_next;
    logic [63:0]            key_low_reg, key_low_next;
    logic [127:0]           rk_reg, rk_next;
    logic [127:0]           blk_reg, blk_next;
    logic                   dec_reg, dec_next;
    logic                   out_valid_reg, out_valid_next;
    logic [127:0]           out_reg, out_next;

    logic                   cfg_we;
    logic                   in_fire;
    logic                   out_free;
    logic                   last_step;
    logic                   advance;
    logic [127:0]           kexp_word;
    logic [RK_ADDR_W-1:0]   raddr;
    logic [127:0]           rk_rdata;
    logic [127:0]           round_out;
    aes_round_ctl_t         round_ctl;

    // APB decode
    assign pready = 1'b1;
    assign cfg_we = psel & penable & pwrite;
    assign prdata = paddr[3] ? key_low_reg : key_high_reg;

    // Handshakes; hold off requests while a key write lands
    assign in_ch.ready     = (state_reg == ST_IDLE) & ~cfg_we;
    assign in_fire         = in_ch.valid & in_ch.ready;
    assign out_ch.valid    = out_valid_reg;
    assign out_ch.out_high = out_reg[127:64];
    assign out_ch.out_low  = out_reg[63:0];
    assign out_free        = ~out_valid_reg | out_ch.ready;

    // Round step control
    assign last_step = (rcnt_reg == LAST_ROUND);
    assign advance   = ~last_step | out_free;
    assign round_ctl = '{decrypt: dec_reg, last: last_step};

    // Key schedule word for the current expansion step
    assign kexp_word = (kcnt_reg == '0) ? {key_high_reg, key_low_reg}
                                        : key_step(rk_reg, kcnt_reg);

    // Round key read address, issued the cycle before the key is used (the RAM read is registered)
    always_comb
    begin
        unique case (state_reg)
            ST_IDLE:  raddr = key_index(in_ch.req_type, '0);
            ST_ADD0:  raddr = key_index(dec_reg, RK_ADDR_W'(1));
            ST_ROUND: raddr = key_index(dec_reg,
                                        (advance && !last_step) ? rcnt_reg + 1'b1 : rcnt_reg);
            default:  raddr = '0;
        endcase
    end

    aes_ram #(
        .WIDTH (128),
        .DEPTH (RK_DEPTH)
    ) u_rk_ram (
        .clk   (clk),
        .we    (state_reg == ST_KEXP),
        .waddr (kcnt_reg),
        .wdata (kexp_word),
        .raddr (raddr),
        .rdata (rk_rdata)
    );

    aes_round u_round (
        .blk       (blk_reg),
        .round_key (rk_rdata),
        .ctl       (round_ctl),
        .result    (round_out)
    );

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        kcnt_next      = kcnt_reg;
        rcnt_next      = rcnt_reg;
        key_high_next  = key_high_reg;
        key_low_next   = key_low_reg;
        rk_next        = rk_reg;
        blk_next       = blk_reg;
        dec_next       = dec_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg & ~out_ch.ready;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    blk_next   = {in_ch.block_high, in_ch.block_low};
                    dec_next   = in_ch.req_type;
                    state_next = ST_ADD0;
                end
            end
            ST_KEXP:
            begin
                rk_next   = kexp_word;
                kcnt_next = kcnt_reg + 1'b1;
                if (kcnt_reg == LAST_ROUND)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_ADD0:
            begin
                blk_next   = blk_reg ^ rk_rdata;
                rcnt_next  = RK_ADDR_W'(1);
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                if (advance)
                begin
                    blk_next  = round_out;
                    rcnt_next = rcnt_reg + 1'b1;
                    if (last_step)
                    begin
                        out_next       = round_out;
                        out_valid_next = 1'b1;
                        state_next     = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Key write restarts the schedule expansion
        if (cfg_we)
        begin
            if (paddr[3])
            begin
                key_low_next = pwdata;
            end
            else
            begin
                key_high_next = pwdata;
            end
            kcnt_next  = '0;
            state_next = ST_KEXP;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_KEXP;
            kcnt_reg      <= '0;
            rcnt_reg      <= '0;
            key_high_reg  <= '0;
            key_low_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            kcnt_reg      <= kcnt_next;
            rcnt_reg      <= rcnt_next;
            key_high_reg  <= key_high_next;
            key_low_reg   <= key_low_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        rk_reg  <= rk_next;
        blk_reg <= blk_next;
        dec_reg <= dec_next;
        out_reg <= out_next;
    end

endmodule
